[rtl/ygp_pkg.sv]
// ----------------------------------------------------------------------------
// ygp_pkg
// Types, constants and register codes shared by the grayscale frame packer.
// ----------------------------------------------------------------------------
package ygp_pkg;

  localparam int unsigned JobQueueDepth = 4;

  localparam logic [9:0] LineLengthReset  = 10'd160;
  localparam logic [9:0] LineCountReset   = 10'd120;
  localparam logic [3:0] PixelFormatReset = 4'd2;

  localparam logic [7:0] HdrMarker   = 8'h00;
  localparam logic [7:0] HdrLength   = 8'h04;
  localparam logic [7:0] HdrNewFrame = 8'h11;
  localparam logic [7:0] PixZeroSub  = 8'h02;

  localparam logic [2:0] HdrLastIdx = 3'd6;
  localparam logic [2:0] PixLastIdx = 3'd1;

  typedef enum logic [1:0] {
    REG_LINE_LENGTH  = 2'd0,
    REG_LINE_COUNT   = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_CAMERA = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PH_Y0 = 2'd0,
    PH_U  = 2'd1,
    PH_Y1 = 2'd2,
    PH_V  = 2'd3
  } phase_e;

  typedef enum logic {
    JOB_HEADER = 1'b0,
    JOB_PIXEL  = 1'b1
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] luma;
    logic       eol;
    logic       eof;
  } job_t;

  typedef struct packed {
    logic [9:0] line_length;
    logic [9:0] line_count;
    logic [3:0] pixel_format;
  } cfg_t;

endpackage

[rtl/ygp_front.sv]
// ----------------------------------------------------------------------------
// ygp_front
// Holds the registers, tracks the Y U Y V phase and the line and frame
// counters, and makes a back-end job of each start and each group in a frame.
// ----------------------------------------------------------------------------
module ygp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [9:0]    cfg_data_i,
  input  logic          accept_i,
  input  logic          cmd_i,
  input  logic [7:0]    camera_byte_i,
  output ygp_pkg::cfg_t cfg_o,
  output logic          job_valid_o,
  output ygp_pkg::job_t job_o
);
  import ygp_pkg::*;

  cfg_t       cfg_q;
  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [8:0] col_q, col_d;
  logic [9:0] row_q, row_d;
  logic       done_q, done_d;
  logic       line_end, frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_length  <= LineLengthReset;
      cfg_q.line_count   <= LineCountReset;
      cfg_q.pixel_format <= PixelFormatReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_LINE_LENGTH) cfg_q.line_length <= cfg_data_i;
      if (cfg_idx_i == REG_LINE_COUNT) cfg_q.line_count <= cfg_data_i;
      if (cfg_idx_i == REG_PIXEL_FORMAT) cfg_q.pixel_format <= cfg_data_i[3:0];
    end
  end

  assign cfg_o = cfg_q;

  assign line_end  = ({1'b0, col_q} + 10'd1) >= {1'b0, cfg_q.line_length[9:1]};
  assign frame_end = ({1'b0, row_q} + 11'd1) >= {1'b0, cfg_q.line_count};

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    col_d       = col_q;
    row_d       = row_q;
    done_d      = done_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      if (cmd_i == CMD_START) begin
        phase_d     = PH_Y0;
        held_d      = '0;
        col_d       = '0;
        row_d       = '0;
        done_d      = 1'b0;
        job_valid_o = 1'b1;
        job_o.kind  = JOB_HEADER;
      end else if (!done_q) begin
        unique case (phase_q)
          PH_Y0: begin
            held_d  = camera_byte_i;
            phase_d = PH_U;
          end
          PH_U: begin
            phase_d = PH_Y1;
          end
          PH_Y1: begin
            held_d  = 8'(({1'b0, held_q} + {1'b0, camera_byte_i}) >> 1);
            phase_d = PH_V;
          end
          PH_V: begin
            phase_d     = PH_Y0;
            job_valid_o = 1'b1;
            job_o.kind  = JOB_PIXEL;
            job_o.luma  = held_q;
            if (line_end) begin
              job_o.eol = 1'b1;
              col_d     = '0;
              if (frame_end) begin
                job_o.eof = 1'b1;
                row_d     = '0;
                done_d    = 1'b1;
              end else begin
                row_d = row_q + 10'd1;
              end
            end else begin
              col_d = col_q + 9'd1;
            end
          end
          default: phase_d = PH_Y0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_Y0;
      held_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
    end
  end

endmodule

[rtl/ygp_job_fifo.sv]
// ----------------------------------------------------------------------------
// ygp_job_fifo
// Short register queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module ygp_job_fifo #(
  parameter int unsigned Depth = ygp_pkg::JobQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ygp_pkg::job_t wdata_i,
  input  logic          pop_i,
  output ygp_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import ygp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      if (do_pop) rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/ygp_back.sv]
// ----------------------------------------------------------------------------
// ygp_back
// Expands each job into its output bytes, one per cycle while the output
// register is empty or popped, into that register.
// ----------------------------------------------------------------------------
module ygp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ygp_pkg::cfg_t cfg_i,
  input  logic          job_empty_i,
  input  ygp_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic          end_of_line_o,
  output logic          end_of_frame_o
);
  import ygp_pkg::*;

  logic       valid_q, valid_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d, eol_q, eol_d, eof_q, eof_d;
  logic       advance, job_last;
  logic [7:0] hdr_pack, hdr_sum, hdr_byte, pix_first, pix_byte;

  assign hdr_pack = {cfg_i.pixel_format, cfg_i.line_count[9:8], cfg_i.line_length[9:8]};
  assign hdr_sum  = HdrNewFrame ^ cfg_i.line_length[7:0] ^ cfg_i.line_count[7:0] ^ hdr_pack;

  always_comb begin
    unique case (idx_q)
      3'd0:    hdr_byte = HdrMarker;
      3'd1:    hdr_byte = HdrLength;
      3'd2:    hdr_byte = HdrNewFrame;
      3'd3:    hdr_byte = cfg_i.line_length[7:0];
      3'd4:    hdr_byte = cfg_i.line_count[7:0];
      3'd5:    hdr_byte = hdr_pack;
      default: hdr_byte = hdr_sum;
    endcase
  end

  assign pix_first = (job_i.luma[7:1] == 7'd0) ? PixZeroSub : {job_i.luma[7:1], 1'b0};
  assign pix_byte  = (idx_q == PixLastIdx) ? {job_i.luma[7:1], 1'b1} : pix_first;

  assign job_last  = (job_i.kind == JOB_HEADER) ? (idx_q == HdrLastIdx)
                                                : (idx_q == PixLastIdx);
  assign advance   = !valid_q || pop_i;
  assign job_pop_o = advance && !job_empty_i && job_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    byte_d  = byte_q;
    last_d  = last_q;
    eol_d   = eol_q;
    eof_d   = eof_q;
    if (advance) begin
      valid_d = !job_empty_i;
      if (!job_empty_i) begin
        byte_d = (job_i.kind == JOB_HEADER) ? hdr_byte : pix_byte;
        last_d = job_last;
        eol_d  = (job_i.kind == JOB_PIXEL) && job_last && job_i.eol;
        eof_d  = (job_i.kind == JOB_PIXEL) && job_last && job_i.eof;
        idx_d  = job_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    eol_q  <= eol_d;
    eof_q  <= eof_d;
  end

  assign empty_o        = !valid_q;
  assign out_byte_o     = byte_q;
  assign last_o         = last_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;

endmodule

[rtl/yuv_gray_uart_frame_packer.sv]
// ----------------------------------------------------------------------------
// yuv_gray_uart_frame_packer
// Turns start commands and YUV422 camera bytes into a grayscale serial byte
// stream with a seven-byte frame header.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// input     push / full         cmd_i, camera_byte_i
// result    empty / pop         out_byte_o, last_o, end_of_line_o, end_of_frame_o
// config    cfg_we_i            cfg_idx_i, cfg_data_i
//
// An input item is taken every cycle while the job queue has room.
// The back end sends one byte per cycle while the result side pops; a header
// is seven bytes and a pixel pair two, and each camera byte is one input item.
// A result is registered from the job at the head of the queue.
// Reset closes any frame and restores the register defaults.
// ----------------------------------------------------------------------------
module yuv_gray_uart_frame_packer #(
  parameter int unsigned JobQueueDepth = ygp_pkg::JobQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic       cmd_i,
  input  logic [7:0] camera_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       end_of_line_o,
  output logic       end_of_frame_o
);
  import ygp_pkg::*;

  cfg_t cfg;
  job_t job_in, job_out;
  logic job_push, job_pop, job_empty, accept;

  assign accept = push && !full;

  ygp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .cmd_i         (cmd_i),
    .camera_byte_i (camera_byte_i),
    .cfg_o         (cfg),
    .job_valid_o   (job_push),
    .job_o         (job_in)
  );

  ygp_job_fifo #(
    .Depth (JobQueueDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .full_o  (full),
    .empty_o (job_empty)
  );

  ygp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

[sim/yuv_gray_uart_frame_packer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuv_gray_uart_frame_packer_tb
// Self-checking testbench for the grayscale frame packer. Start commands and
// camera bytes are fed through the input queue, and every output transfer is
// compared with a predictor of the header and pixel-pair byte stream. Both
// sides idle at random, the output side holds off once for a long stretch,
// and the registers are reprogrammed between phases, including the extremes.
// ----------------------------------------------------------------------------
module yuv_gray_uart_frame_packer_tb;
  import ygp_pkg::*;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 2000;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] cb;
  } packer_input_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eol;
    logic       eof;
  } packer_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_idx_i     = '0;
  logic [9:0] cfg_data_i    = '0;
  logic       push          = 1'b0;
  logic       full;
  logic       cmd_i         = 1'b0;
  logic [7:0] camera_byte_i = '0;
  logic       empty;
  logic       pop           = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       end_of_line_o;
  logic       end_of_frame_o;

  packer_input_t  pending_inputs[$];
  packer_result_t expected_results[$];
  packer_input_t  next_input;
  packer_result_t want_result;

  logic [9:0] cfg_len   = LineLengthReset;
  logic [9:0] cfg_lines = LineCountReset;
  logic [3:0] cfg_fmt   = PixelFormatReset;

  phase_e     luma_phase = PH_Y0;
  logic [7:0] held_luma  = '0;
  logic [8:0] pair_col   = '0;
  logic [9:0] row_idx    = '0;
  logic       frame_shut = 1'b1;

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned send_calm    = 0;
  int unsigned recv_gap     = 0;
  int unsigned recv_calm    = 0;
  int unsigned hold_left    = 0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;

  yuv_gray_uart_frame_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .cmd_i         (cmd_i),
    .camera_byte_i (camera_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .end_of_line_o (end_of_line_o),
    .end_of_frame_o(end_of_frame_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned idle_gap(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_result(logic [7:0] data, logic last, logic eol, logic eof);
    expected_results.push_back('{data, last, eol, eof});
  endfunction

  task automatic predict_packer_bytes(input cmd_e cmd, input logic [7:0] cb);
    logic [7:0] shape;
    logic [7:0] first;
    logic       eol;
    logic       eof;
    if (cmd == CMD_START) begin
      shape = {cfg_fmt, cfg_lines[9:8], cfg_len[9:8]};
      queue_result(HdrMarker, 1'b0, 1'b0, 1'b0);
      queue_result(HdrLength, 1'b0, 1'b0, 1'b0);
      queue_result(HdrNewFrame, 1'b0, 1'b0, 1'b0);
      queue_result(cfg_len[7:0], 1'b0, 1'b0, 1'b0);
      queue_result(cfg_lines[7:0], 1'b0, 1'b0, 1'b0);
      queue_result(shape, 1'b0, 1'b0, 1'b0);
      queue_result(HdrNewFrame ^ cfg_len[7:0] ^ cfg_lines[7:0] ^ shape, 1'b1, 1'b0, 1'b0);
      luma_phase = PH_Y0;
      held_luma  = '0;
      pair_col   = '0;
      row_idx    = '0;
      frame_shut = 1'b0;
    end else if (!frame_shut) begin
      case (luma_phase)
        PH_Y0: begin
          held_luma  = cb;
          luma_phase = PH_U;
        end
        PH_U: luma_phase = PH_Y1;
        PH_Y1: begin
          held_luma  = 8'((9'(held_luma) + 9'(cb)) >> 1);
          luma_phase = PH_V;
        end
        default: begin
          first = {held_luma[7:1], 1'b0};
          if (first == 8'h00) first = PixZeroSub;
          eol = 1'b0;
          eof = 1'b0;
          luma_phase = PH_Y0;
          if (int'(pair_col) + 1 >= int'(cfg_len >> 1)) begin
            eol      = 1'b1;
            pair_col = '0;
            if (int'(row_idx) + 1 >= int'(cfg_lines)) begin
              eof        = 1'b1;
              row_idx    = '0;
              frame_shut = 1'b1;
            end else begin
              row_idx = row_idx + 10'd1;
            end
          end else begin
            pair_col = pair_col + 9'd1;
          end
          queue_result(first, 1'b0, 1'b0, 1'b0);
          queue_result(held_luma | 8'h01, 1'b1, eol, eof);
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push          <= 1'b0;
      cmd_i         <= CMD_START;
      camera_byte_i <= '0;
    end else begin
      if (push && !full) predict_packer_bytes(cmd_e'(cmd_i), camera_byte_i);
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_inputs.size() != 0) begin
          next_input    = pending_inputs.pop_front();
          push          <= 1'b1;
          cmd_i         <= next_input.cmd;
          camera_byte_i <= next_input.cb;
          send_gap      = idle_gap(send_calm);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: byte %02h last %0b eol %0b eof %0b",
                     out_byte_o, last_o, end_of_line_o, end_of_frame_o);
        end else begin
          want_result = expected_results.pop_front();
          if (out_byte_o !== want_result.data || last_o !== want_result.last ||
              end_of_line_o !== want_result.eol || end_of_frame_o !== want_result.eof) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                       want_result.data, want_result.last, want_result.eol, want_result.eof,
                       out_byte_o, last_o, end_of_line_o, end_of_frame_o);
          end
        end
        recv_gap = idle_gap(recv_calm);
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
        pop <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("yuv_gray_uart_frame_packer_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic void add_item(cmd_e cmd, logic [7:0] cb);
    pending_inputs.push_back('{cmd, cb});
  endfunction

  function automatic void add_group(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                    logic [7:0] v);
    add_item(CMD_CAMERA, y0);
    add_item(CMD_CAMERA, u);
    add_item(CMD_CAMERA, y1);
    add_item(CMD_CAMERA, v);
  endfunction

  function automatic logic [7:0] rand_luma();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_inputs.size() != 0 || push || expected_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [9:0] len, input logic [9:0] lines,
                              input logic [3:0] fmt);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LINE_LENGTH;
    cfg_data_i <= len;
    cfg_len    = len;
    @(posedge clk_i);
    cfg_idx_i  <= REG_LINE_COUNT;
    cfg_data_i <= lines;
    cfg_lines  = lines;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PIXEL_FORMAT;
    cfg_data_i <= {6'd0, fmt};
    cfg_fmt    = fmt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Whole frames with random content, some cut short by the next start and
  // some followed by a group that arrives after the frame has ended.
  task automatic queue_frames(input int unsigned budget);
    int unsigned added;
    int unsigned pairs;
    int unsigned lines;
    int unsigned total;
    int unsigned groups;
    int unsigned roll;
    added = 0;
    pairs = ((cfg_len >> 1) == 0) ? 1 : int'(cfg_len >> 1);
    lines = (cfg_lines == 0) ? 1 : int'(cfg_lines);
    total = pairs * lines;
    while (added < budget) begin
      add_item(CMD_START, 8'($urandom));
      added++;
      roll = $urandom_range(0, 99);
      if (roll < 70) groups = total;
      else if (roll < 85) groups = $urandom_range(1, total);
      else groups = total + 1;
      if (groups > (budget - added) / 4 + 1) groups = (budget - added) / 4 + 1;
      repeat (groups) begin
        if ($urandom_range(0, 24) == 0) begin
          add_item(CMD_CAMERA, 8'($urandom));
          added++;
        end
        add_group(rand_luma(), 8'($urandom), rand_luma(), 8'($urandom));
        added += 4;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_item(CMD_CAMERA, 8'h5A);
    add_item(CMD_START, 8'hA5);
    add_group(8'h00, 8'hFF, 8'h01, 8'h80);
    add_group(8'hFF, 8'h00, 8'hFF, 8'h7F);
    add_item(CMD_START, 8'h00);
    add_group(8'h81, 8'hAA, 8'h02, 8'h55);
    wait_drained();

    program_regs(10'd2, 10'd1, 4'hF);
    add_item(CMD_START, 8'hFF);
    add_group(8'h7E, 8'h01, 8'h80, 8'hFE);
    add_item(CMD_CAMERA, 8'h33);
    add_item(CMD_CAMERA, 8'hCC);
    wait_drained();

    program_regs(10'd1, 10'd0, 4'h0);
    add_item(CMD_START, 8'h5A);
    add_group(8'h40, 8'h3C, 8'hC3, 8'h0F);
    add_group(8'hF0, 8'h99, 8'h0F, 8'h66);
    wait_drained();

    program_regs(10'($urandom_range(2, 8)), 10'($urandom_range(1, 3)), 4'($urandom));
    hold_req <= 1'b1;
    queue_frames(20);
    wait_drained();

    program_regs(10'd1022, 10'd1023, 4'd2);
    queue_frames(12);
    wait_drained();

    // The frame is still open, so the new sizes end its current line part way.
    program_regs(10'd5, 10'd2, 4'($urandom));
    add_group(rand_luma(), 8'($urandom), rand_luma(), 8'($urandom));
    add_group(rand_luma(), 8'($urandom), rand_luma(), 8'($urandom));
    queue_frames(14);
    wait_drained();

    program_regs(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 4'($urandom));
    queue_frames(10);
    wait_drained();

    program_regs(10'd1023, 10'($urandom_range(0, 3)), 4'($urandom));
    queue_frames(8);
    wait_drained();

    program_regs(10'($urandom_range(0, 6)), 10'($urandom_range(0, 3)), 4'($urandom));
    queue_frames(12);
    wait_drained();

    if (mismatches == 0) begin
      $display("yuv_gray_uart_frame_packer_tb: PASS");
    end else begin
      $display("yuv_gray_uart_frame_packer_tb: FAIL");
    end
    $finish;
  end

endmodule
